>>> sv/dvc_pkg.sv
// ----------------------------------------------------------------------------
// dvc_pkg
// Shared types and constants of the distance and visibility classifier:
// payload structs, register indexes, class codes and controller commands.
// ----------------------------------------------------------------------------
package dvc_pkg;

  localparam int unsigned COORD_W      = 24;
  localparam int unsigned DIST_W       = 24;
  localparam int unsigned TALLY_W      = 13;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned CFG_DATA_W   = 24;
  localparam int unsigned SQ_W         = 2 * COORD_W;
  localparam int unsigned RAD_W        = SQ_W + 2;
  localparam int unsigned ROOT_W       = RAD_W / 2;
  localparam int unsigned REM_W        = ROOT_W + 2;
  localparam int unsigned ROOT_STEPS   = ROOT_W;
  localparam int unsigned STEP_CNT_W   = $clog2(ROOT_STEPS);
  localparam int unsigned TALLY_CAP    = (1 << TALLY_W) - 1;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_OBSERVER_X      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OBSERVER_Y      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DETECTION_RANGE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CLOSE_RADIUS    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OBSERVER_ASLEEP = 3'd4;

  localparam logic [DIST_W-1:0] CLOSE_RADIUS_RESET = 24'd5120;
  localparam logic [DIST_W-1:0] DIST_MAX           = {DIST_W{1'b1}};

  typedef enum logic [1:0] {
    CLASS_HIDDEN    = 2'd0,
    CLASS_COULD_SEE = 2'd1,
    CLASS_VISIBLE   = 2'd2
  } vis_class_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] object_x;
    logic signed [COORD_W-1:0] object_y;
    logic                      could_see;
    logic                      can_see;
    logic                      last_object;
  } dvc_in_t;

  typedef struct packed {
    logic [DIST_W-1:0]  distance;
    logic [1:0]         visibility_class;
    logic [TALLY_W-1:0] close_count;
    logic               pass_done;
  } dvc_out_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load_in;
    logic load_diff;
    logic sq_x;
    logic sq_y;
    logic load_rad;
    logic root_step;
    logic finish;
  } dvc_cmd_t;

endpackage

>>> sv/distance_visibility_classifier.sv
// One object at a time: a new transaction is accepted only once the last has
// gone through the difference, two squaring and sum steps, the 25-step root
// digit recurrence in the datapath and the result register.
// A finished result waits in the output register while the next object runs.
// Reset (rst_ni low, asynchronous) clears the controller, the close tally
// and the configuration registers to their defaults (close radius 20.0).
// ----------------------------------------------------------------------------
// distance_visibility_classifier
// Computes each object's distance to the observer, its visibility class and
// the running count of close objects in the current pass.
// ----------------------------------------------------------------------------
module distance_visibility_classifier #(
  parameter int unsigned MAX_OBJECTS = 4096
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  dvc_pkg::dvc_in_t               in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output dvc_pkg::dvc_out_t              out_data_o,
  input  logic                           cfg_we_i,
  input  logic [dvc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [dvc_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import dvc_pkg::*;

  localparam int unsigned LIMIT_INT = (MAX_OBJECTS < TALLY_CAP) ? MAX_OBJECTS : TALLY_CAP;
  localparam logic [TALLY_W-1:0] TALLY_LIMIT = TALLY_W'(LIMIT_INT);

  dvc_cmd_t cmd;

  dvc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  dvc_dpath #(
    .MAX_OBJECTS (MAX_OBJECTS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_data_o  (out_data_o)
  );

`ifndef SYNTHESIS
  // Busy after an accepted transaction
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("classifier accepted a transaction while busy");

  // Tally stays within its limit
  a_tally_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.close_count <= TALLY_LIMIT))
    else $error("close count above limit");

  // Only defined class codes are delivered
  a_class_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.visibility_class != 2'd3))
    else $error("undefined visibility class");
`endif

endmodule

>>> sv/dvc_ctrl.sv
// ----------------------------------------------------------------------------
// dvc_ctrl
// Sequencer of the classifier: steps one object through difference,
// squaring, summing, the root recurrence and the result register.
// ----------------------------------------------------------------------------
module dvc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output dvc_pkg::dvc_cmd_t cmd_o
);
  import dvc_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIFF = 3'd1;
  localparam logic [2:0] ST_SQX  = 3'd2;
  localparam logic [2:0] ST_SQY  = 3'd3;
  localparam logic [2:0] ST_SUM  = 3'd4;
  localparam logic [2:0] ST_ROOT = 3'd5;
  localparam logic [2:0] ST_FIN  = 3'd6;

  localparam logic [STEP_CNT_W-1:0] LAST_STEP = STEP_CNT_W'(ROOT_STEPS - 1);

  logic [2:0]            state_q, state_d;
  logic [STEP_CNT_W-1:0] cnt_q, cnt_d;
  logic                  out_valid_q, out_valid_d;
  logic                  out_free;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || out_ready_i;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = ST_DIFF;
        end
      end
      ST_DIFF: begin
        cmd_o.load_diff = 1'b1;
        state_d         = ST_SQX;
      end
      ST_SQX: begin
        cmd_o.sq_x = 1'b1;
        state_d    = ST_SQY;
      end
      ST_SQY: begin
        cmd_o.sq_y = 1'b1;
        state_d    = ST_SUM;
      end
      ST_SUM: begin
        cmd_o.load_rad = 1'b1;
        cnt_d          = '0;
        state_d        = ST_ROOT;
      end
      ST_ROOT: begin
        cmd_o.root_step = 1'b1;
        cnt_d           = cnt_q + 1'b1;
        if (cnt_q == LAST_STEP) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        // Hold until the result register is free
        if (out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Result register occupancy
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.finish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

>>> sv/dvc_dpath.sv
// ----------------------------------------------------------------------------
// dvc_dpath
// Datapath of the classifier: configuration registers, absolute
// differences, shared squarer, radix-2 digit recurrence for the root,
// classification, close tally and result register.
// ----------------------------------------------------------------------------
module dvc_dpath #(
  parameter int unsigned MAX_OBJECTS = 4096
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  dvc_pkg::dvc_cmd_t                cmd_i,
  input  dvc_pkg::dvc_in_t                 in_data_i,
  input  logic                             cfg_we_i,
  input  logic [dvc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [dvc_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  output dvc_pkg::dvc_out_t                out_data_o
);
  import dvc_pkg::*;

  localparam int unsigned LIMIT_INT = (MAX_OBJECTS < TALLY_CAP) ? MAX_OBJECTS : TALLY_CAP;
  localparam logic [TALLY_W-1:0] TALLY_LIMIT = TALLY_W'(LIMIT_INT);

  // Configuration registers
  logic signed [COORD_W-1:0] obs_x_q, obs_y_q;
  logic [DIST_W-1:0]         det_range_q, close_radius_q;
  logic                      asleep_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      obs_x_q        <= '0;
      obs_y_q        <= '0;
      det_range_q    <= '0;
      close_radius_q <= CLOSE_RADIUS_RESET;
      asleep_q       <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_OBSERVER_X:      obs_x_q        <= cfg_wdata_i;
        REG_OBSERVER_Y:      obs_y_q        <= cfg_wdata_i;
        REG_DETECTION_RANGE: det_range_q    <= cfg_wdata_i;
        REG_CLOSE_RADIUS:    close_radius_q <= cfg_wdata_i;
        REG_OBSERVER_ASLEEP: asleep_q       <= cfg_wdata_i[0];
        default: begin
        end
      endcase
    end
  end

  // Captured transaction
  dvc_in_t item_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      item_q <= in_data_i;
    end
  end

  // Absolute differences; the magnitude always fits the coordinate width
  logic signed [COORD_W:0] diff_x, diff_y;
  logic [COORD_W:0]        mag_x, mag_y;
  logic [COORD_W-1:0]      dx_q, dy_q;

  assign diff_x = {obs_x_q[COORD_W-1], obs_x_q} - {item_q.object_x[COORD_W-1], item_q.object_x};
  assign diff_y = {obs_y_q[COORD_W-1], obs_y_q} - {item_q.object_y[COORD_W-1], item_q.object_y};
  assign mag_x  = diff_x[COORD_W] ? (~diff_x + 1'b1) : diff_x;
  assign mag_y  = diff_y[COORD_W] ? (~diff_y + 1'b1) : diff_y;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_diff) begin
      dx_q <= mag_x[COORD_W-1:0];
      dy_q <= mag_y[COORD_W-1:0];
    end
  end

  // Shared squarer: dx in one cycle, dy in the next
  logic [COORD_W-1:0] sq_op;
  logic [SQ_W-1:0]    prod_q, sqx_q;

  assign sq_op = cmd_i.sq_x ? dx_q : dy_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.sq_x || cmd_i.sq_y) begin
      prod_q <= sq_op * sq_op;
    end
    if (cmd_i.sq_y) begin
      sqx_q <= prod_q;
    end
  end

  // Root recurrence: one result bit and two radicand bits per step
  logic [RAD_W-1:0]  rad_q;
  logic [REM_W-1:0]  rem_q;
  logic [ROOT_W-1:0] root_q;
  logic [REM_W+1:0]  rem_sh, trial, rem_sub;
  logic              take;

  assign rem_sh  = {rem_q, rad_q[RAD_W-1 -: 2]};
  assign trial   = {2'b00, root_q, 2'b01};
  assign take    = (rem_sh >= trial);
  assign rem_sub = rem_sh - trial;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_rad) begin
      rad_q  <= RAD_W'(sqx_q) + RAD_W'(prod_q);
      rem_q  <= '0;
      root_q <= '0;
    end else if (cmd_i.root_step) begin
      rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
      rem_q  <= take ? rem_sub[REM_W-1:0] : rem_sh[REM_W-1:0];
      root_q <= {root_q[ROOT_W-2:0], take};
    end
  end

  // Saturate, classify and count
  logic [DIST_W-1:0]  dist_sat;
  logic               is_close;
  logic               visible;
  vis_class_e         vis_class;
  logic [TALLY_W-1:0] tally_q, tally_next;

  assign dist_sat = (|root_q[ROOT_W-1:DIST_W]) ? DIST_MAX : root_q[DIST_W-1:0];
  assign is_close = (dist_sat < close_radius_q);
  assign visible = !asleep_q &&
                   (item_q.can_see || (item_q.could_see && (dist_sat < det_range_q)));

  always_comb begin
    if (visible) begin
      vis_class = CLASS_VISIBLE;
    end else if (item_q.could_see) begin
      vis_class = CLASS_COULD_SEE;
    end else begin
      vis_class = CLASS_HIDDEN;
    end
  end

  assign tally_next = (is_close && (tally_q < TALLY_LIMIT)) ? (tally_q + 1'b1) : tally_q;

  // Restart the tally after the last object of a pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tally_q <= '0;
    end else if (cmd_i.finish) begin
      tally_q <= item_q.last_object ? '0 : tally_next;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_data_o.distance         <= dist_sat;
      out_data_o.visibility_class <= vis_class;
      out_data_o.close_count      <= tally_next;
      out_data_o.pass_done        <= item_q.last_object;
    end
  end

endmodule
